// ===== sv/pbin_pkg.sv =====
`timescale 1ns / 1ps

package pbin_pkg;

  localparam int SUM_W        = 24;
  localparam int ROW_W        = 10;
  localparam int COL_W        = 10;
  localparam int FACTOR_CFG_W = 5;
  localparam int SIZE_CFG_W   = 11;
  localparam int CFG_IDX_W    = 2;
  localparam int OUT_ROWS_MAX = 1024;

  // Output queue: depth and the width of its fill count.
  localparam int OQ_DEPTH = 3;
  localparam int OQ_CNT_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BIN_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS   = 2'd2;

  // What the position tracker hands to the accumulate stage for one sample.
  typedef struct packed {
    logic             wr;        // end of a block sub-row: line entry is updated
    logic             first;     // first sub-row of the block row: entry is overwritten
    logic             emit;      // last sample of a block
    logic             last_pix;  // last pixel of the frame
    logic [ROW_W-1:0] row;
    logic [SUM_W-1:0] part;      // horizontal partial sum including this sample
  } step_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_pix;
  } pix_t;

endpackage

// ===== sv/pbin_ram.sv =====
`timescale 1ns / 1ps

module pbin_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pbin_ctrl.sv =====
`timescale 1ns / 1ps

module pbin_ctrl #(
  parameter int MAX_OUT_COLS = 1024,
  parameter int MAX_FACTOR   = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                                                     clk,
  input  logic                                                     rst,
  input  logic                                                     accept,
  input  logic [SAMPLE_BITS-1:0]                                   sample,
  input  logic                                                     frame_start,
  input  logic [pbin_pkg::FACTOR_CFG_W-1:0]                        bin_factor,
  input  logic [pbin_pkg::SIZE_CFG_W-1:0]                          out_rows,
  input  logic [pbin_pkg::SIZE_CFG_W-1:0]                          out_cols,
  output logic [(MAX_OUT_COLS > 1 ? $clog2(MAX_OUT_COLS) : 1)-1:0] col,
  output pbin_pkg::step_t                                          step
);

  import pbin_pkg::*;

  localparam int AW  = MAX_OUT_COLS > 1 ? $clog2(MAX_OUT_COLS) : 1;
  localparam int FW  = MAX_FACTOR > 1 ? $clog2(MAX_FACTOR) : 1;
  localparam int FCW = $clog2(MAX_FACTOR + 1);
  localparam int FEW = FCW > FACTOR_CFG_W ? FCW : FACTOR_CFG_W;
  localparam int CCW = $clog2(MAX_OUT_COLS + 1);
  localparam int CEW = CCW > SIZE_CFG_W ? CCW : SIZE_CFG_W;

  logic [FW-1:0]         sub_col, sub_col_next, sc;
  logic [FW-1:0]         sub_row, sub_row_next, sr;
  logic [AW-1:0]         out_col, out_col_next, oc;
  logic [ROW_W-1:0]      out_row, out_row_next, orow;
  logic [SUM_W-1:0]      row_partial, row_partial_next, part;
  logic [FEW-1:0]        f_raw, f_eff;
  logic [CEW-1:0]        c_raw, c_eff;
  logic [SIZE_CFG_W-1:0] r_eff;
  logic                  end_sub, last_row, col_last, row_last;

  always_comb begin
    // Register values out of range act as the nearest legal value.
    f_raw = FEW'(bin_factor);
    if (f_raw == '0) begin
      f_eff = FEW'(1);
    end else if (f_raw > FEW'(MAX_FACTOR)) begin
      f_eff = FEW'(MAX_FACTOR);
    end else begin
      f_eff = f_raw;
    end
    c_raw = CEW'(out_cols);
    if (c_raw == '0) begin
      c_eff = CEW'(1);
    end else if (c_raw > CEW'(MAX_OUT_COLS)) begin
      c_eff = CEW'(MAX_OUT_COLS);
    end else begin
      c_eff = c_raw;
    end
    if (out_rows == '0) begin
      r_eff = SIZE_CFG_W'(1);
    end else if (out_rows > SIZE_CFG_W'(OUT_ROWS_MAX)) begin
      r_eff = SIZE_CFG_W'(OUT_ROWS_MAX);
    end else begin
      r_eff = out_rows;
    end

    // A frame start places this very sample at position zero.
    sc   = frame_start ? '0 : sub_col;
    sr   = frame_start ? '0 : sub_row;
    oc   = frame_start ? '0 : out_col;
    orow = frame_start ? '0 : out_row;

    part = (sc == '0) ? SUM_W'(sample) : row_partial + SUM_W'(sample);

    end_sub  = !((FEW'(sc) + FEW'(1)) < f_eff);
    last_row = !((FEW'(sr) + FEW'(1)) < f_eff);
    col_last = !((CEW'(oc) + CEW'(1)) < c_eff);
    row_last = !((SIZE_CFG_W'(orow) + SIZE_CFG_W'(1)) < r_eff);

    sub_col_next     = sc;
    sub_row_next     = sr;
    out_col_next     = oc;
    out_row_next     = orow;
    row_partial_next = part;
    if (!end_sub) begin
      sub_col_next = sc + FW'(1);
    end else begin
      sub_col_next     = '0;
      row_partial_next = '0;
      if (!col_last) begin
        out_col_next = oc + AW'(1);
      end else begin
        out_col_next = '0;
        if (!last_row) begin
          sub_row_next = sr + FW'(1);
        end else begin
          sub_row_next = '0;
          out_row_next = row_last ? '0 : orow + ROW_W'(1);
        end
      end
    end

    step.wr       = end_sub;
    step.first    = (sr == '0);
    step.emit     = end_sub && last_row;
    step.last_pix = row_last && col_last;
    step.row      = orow;
    step.part     = part;
    col           = oc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub_col     <= '0;
      sub_row     <= '0;
      out_col     <= '0;
      out_row     <= '0;
      row_partial <= '0;
    end else if (accept) begin
      sub_col     <= sub_col_next;
      sub_row     <= sub_row_next;
      out_col     <= out_col_next;
      out_row     <= out_row_next;
      row_partial <= row_partial_next;
    end
  end

endmodule

// ===== sv/pbin_outq.sv =====
`timescale 1ns / 1ps

module pbin_outq (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  pbin_pkg::pix_t                din,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pbin_pkg::pix_t                dout,
  output logic [pbin_pkg::OQ_CNT_W-1:0] count
);

  import pbin_pkg::*;

  pix_t                q [OQ_DEPTH];
  logic [OQ_CNT_W-1:0] wptr, rptr;
  logic                pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  assign dout      = q[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == OQ_CNT_W'(OQ_DEPTH - 1)) ? '0 : wptr + OQ_CNT_W'(1);
      end
      if (pop) begin
        rptr <= (rptr == OQ_CNT_W'(OQ_DEPTH - 1)) ? '0 : rptr + OQ_CNT_W'(1);
      end
      if (push && !pop) begin
        count <= count + OQ_CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - OQ_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= din;
    end
  end

endmodule

// ===== sv/pixel_block_binning.sv =====
`timescale 1ns / 1ps
// Box-sum binning of a sub-pixel raster stream.
// Input channel (in_valid/in_ready) carries one sample per beat in raster order;
// frame_start on a beat places that sample at the top-left of a new frame.
// Output channel (out_valid/out_ready) carries one beat per finished block:
// the block sum, its row and column, and frame_end on the last pixel of a frame.
// Registers 0 bin_factor, 1 out_rows, 2 out_cols are written via cfg_write,
// cfg_index and cfg_data; the user must keep the stream idle then (unenforced).
// Throughput is one sample per cycle while in_ready is high. The line
// accumulator RAM is read in the cycle a sample that ends a block sub-row is
// taken and written back in the next cycle; a back-to-back update of the same
// column is forwarded around the RAM. A block's result goes from the accumulate
// stage register into the output queue, which drives the output channel.
// A three-beat output queue holds results while the receiver stalls; in_ready
// drops while the queued results plus the one in flight fill all three entries.
// Reset sets all registers to 1 and the position counters to zero. The RAM is
// not cleared: each entry is written on the first sub-row of a block row.
module pixel_block_binning #(
  parameter int MAX_OUT_COLS = 1024,
  parameter int MAX_FACTOR   = 16,
  parameter int SAMPLE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pbin_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbin_pkg::SIZE_CFG_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pbin_pkg::SUM_W-1:0]         pixel_sum,
  output logic [pbin_pkg::ROW_W-1:0]         pixel_row,
  output logic [pbin_pkg::COL_W-1:0]         pixel_col,
  output logic                               frame_end
);

  import pbin_pkg::*;

  localparam int AW = MAX_OUT_COLS > 1 ? $clog2(MAX_OUT_COLS) : 1;

  logic [FACTOR_CFG_W-1:0] bin_factor;
  logic [SIZE_CFG_W-1:0]   out_rows, out_cols;

  logic                accept;
  step_t               step, s1_step;
  logic [AW-1:0]       col, s1_col;
  logic                s1_valid, s1_emit;
  logic                fwd;
  logic [SUM_W-1:0]    fwd_data, rdata, base, total;
  pix_t                pix, oq_dout;
  logic [OQ_CNT_W-1:0] oq_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_factor <= FACTOR_CFG_W'(1);
      out_rows   <= SIZE_CFG_W'(1);
      out_cols   <= SIZE_CFG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BIN_FACTOR: bin_factor <= cfg_data[FACTOR_CFG_W-1:0];
        REG_OUT_ROWS:   out_rows   <= cfg_data;
        REG_OUT_COLS:   out_cols   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_emit  = s1_valid && s1_step.emit;
  assign in_ready = (({1'b0, oq_count} + (OQ_CNT_W + 1)'(s1_emit)) < (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign accept   = in_valid && in_ready;

  pbin_ctrl #(
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .MAX_FACTOR   (MAX_FACTOR),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .sample      (sample),
    .frame_start (frame_start),
    .bin_factor  (bin_factor),
    .out_rows    (out_rows),
    .out_cols    (out_cols),
    .col         (col),
    .step        (step)
  );

  pbin_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_OUT_COLS)
  ) u_line (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (total),
    .re    (accept && step.wr),
    .raddr (col),
    .rdata (rdata)
  );

  // Accumulate stage: never stalls, so the RAM data is consumed the cycle it arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept && step.wr;
    end
  end

  // The write of the item now in this stage lands after the next read has
  // already sampled the RAM, so a repeat of the same column takes the new sum.
  always_ff @(posedge clk) begin
    s1_step  <= step;
    s1_col   <= col;
    fwd      <= s1_valid && (s1_col == col);
    fwd_data <= total;
  end

  always_comb begin
    base  = fwd ? fwd_data : rdata;
    total = s1_step.first ? s1_step.part : base + s1_step.part;
  end

  assign pix.sum      = total;
  assign pix.row      = s1_step.row;
  assign pix.col      = COL_W'(s1_col);
  assign pix.last_pix = s1_step.last_pix;

  pbin_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_emit),
    .din       (pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (oq_dout),
    .count     (oq_count)
  );

  assign pixel_sum = oq_dout.sum;
  assign pixel_row = oq_dout.row;
  assign pixel_col = oq_dout.col;
  assign frame_end = oq_dout.last_pix;

  a_forward: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && $past(s1_valid) && ($past(s1_col) == s1_col)) |-> fwd)
    else $error("back-to-back update of one column was not forwarded");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    (({1'b0, oq_count} + (OQ_CNT_W + 1)'(s1_emit)) <= (OQ_CNT_W + 1)'(OQ_DEPTH)))
    else $error("output queue overcommitted");

endmodule
